// File: rtl/lfk_pkg.sv
// Shared types, constants and arithmetic helpers for the leg forward kinematics block.
package lfk_pkg;

  localparam int LEG_COUNT_DEF = 6;
  localparam int LEG_SLOTS = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [3:0] CFG_HIP_OFFSET   = 4'd0;
  localparam logic [3:0] CFG_KNEE_OFFSET  = 4'd1;
  localparam logic [3:0] CFG_ANKLE_OFFSET = 4'd2;
  localparam logic [3:0] CFG_COXA_REACH   = 4'd3;
  localparam logic [3:0] CFG_COXA_RISE    = 4'd4;
  localparam logic [3:0] CFG_FEMUR_REACH  = 4'd5;
  localparam logic [3:0] CFG_TIBIA_REACH  = 4'd6;
  localparam logic [3:0] CFG_SENSOR_MOUNT = 4'd7;

  typedef logic signed [32:0] trig_t;
  typedef logic signed [23:0] zang_t;
  typedef logic signed [23:0] vec_t;
  typedef logic signed [57:0] prod_t;
  typedef logic signed [12:0] rem_t;

  localparam trig_t CORDIC_GAIN = 33'sd652032874;
  localparam prod_t HALF_Q30 = 58'sd536870912;
  localparam vec_t POS_MIN = -24'sd32768;
  localparam vec_t POS_MAX = 24'sd32767;
  localparam vec_t DIR_MIN = -24'sd16384;
  localparam vec_t DIR_MAX = 24'sd16384;

  localparam zang_t ATAN_TAB [CORDIC_STEPS] = '{
    24'sd737280, 24'sd435242, 24'sd229970, 24'sd116736, 24'sd58595, 24'sd29326,
    24'sd14667, 24'sd7334, 24'sd3667, 24'sd1833, 24'sd917, 24'sd458,
    24'sd229, 24'sd115, 24'sd57, 24'sd29
  };

  localparam logic signed [15:0] ORG_X [LEG_SLOTS] = '{
    16'sd1075, 16'sd1669, 16'sd1075, -16'sd1075, -16'sd1669, -16'sd1075, 16'sd0, 16'sd0
  };
  localparam logic signed [15:0] ORG_Y [LEG_SLOTS] = '{
    16'sd1203, 16'sd0, -16'sd1203, 16'sd1203, 16'sd0, -16'sd1203, 16'sd0, 16'sd0
  };
  localparam logic signed [15:0] ORG_Z [LEG_SLOTS] = '{
    16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd0, 16'sd0
  };
  localparam logic signed [15:0] YAW_TAB [LEG_SLOTS] = '{
    -16'sd2880, -16'sd5760, -16'sd8640, 16'sd2880, 16'sd5760, 16'sd8640, 16'sd0, 16'sd0
  };

  typedef struct packed {
    logic [1:0] qq;
    rem_t       r;
  } split_t;

  // Angle slots: 0 hip, 1 knee, 2 ankle, 3 mounting yaw.
  typedef struct packed {
    logic          mode;
    logic [2:0]    leg;
    logic          ok;
    split_t [3:0]  ang;
  } q_item_t;

  typedef struct packed {
    logic signed [15:0] hip_offset;
    logic signed [15:0] knee_offset;
    logic signed [15:0] ankle_offset;
    logic signed [15:0] coxa_reach;
    logic signed [15:0] coxa_rise;
    logic signed [15:0] femur_reach;
    logic signed [15:0] tibia_reach;
    logic [31:0]        sensor_mount;
  } cfg_t;

  typedef struct packed {
    trig_t x;
    trig_t y;
    zang_t z;
  } cstate_t;

  // Wraps a sum of angle and offset to one turn and splits it into a quarter
  // turn count and a remainder in [-2880, 2880).
  function automatic split_t split_angle(input logic signed [16:0] a);
    logic signed [18:0] t;
    logic [16:0] u;
    logic signed [18:0] rr;
    split_t o;
    t = 19'(a) + 19'sd69120;
    u = t[16:0];
    if (u >= 17'd92160) u = u - 17'd92160;
    if (u >= 17'd46080) u = u - 17'd46080;
    if (u >= 17'd23040) u = u - 17'd23040;
    rr = $signed({2'b00, u});
    if (u < 17'd2880) begin
      o.qq = 2'd0;
    end else if (u < 17'd8640) begin
      o.qq = 2'd1;
      rr = rr - 19'sd5760;
    end else if (u < 17'd14400) begin
      o.qq = 2'd2;
      rr = rr - 19'sd11520;
    end else if (u < 17'd20160) begin
      o.qq = 2'd3;
      rr = rr - 19'sd17280;
    end else begin
      o.qq = 2'd0;
      rr = rr - 19'sd23040;
    end
    o.r = rr[12:0];
    return o;
  endfunction

  function automatic cstate_t cordic_step(input cstate_t v, input int i);
    cstate_t o;
    trig_t dx;
    trig_t dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (v.z >= 0) begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - ATAN_TAB[i];
    end else begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + ATAN_TAB[i];
    end
    return o;
  endfunction

  // Round a Q30 product sum to an integer, ties toward plus infinity.
  function automatic vec_t rnd30(input prod_t v);
    prod_t t;
    t = (v + HALF_Q30) >>> 30;
    return vec_t'(t);
  endfunction

  function automatic logic [15:0] sat16(input vec_t v, input vec_t lo, input vec_t hi);
    vec_t t;
    t = v;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    return t[15:0];
  endfunction

endpackage

// File: rtl/lfk_queue.sv
// Short queue between the classifying front end and the arithmetic back end.
module lfk_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lfk_pkg::q_item_t wr_item,
  output logic             full,
  input  logic             pop,
  output lfk_pkg::q_item_t rd_item,
  output logic             empty
);
  import lfk_pkg::*;

  q_item_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/lfk_front.sv
// Front end: takes a pose query, adds joint offsets, wraps angles and looks up the mount yaw.
module lfk_front #(
  parameter int LEG_COUNT = lfk_pkg::LEG_COUNT_DEF
) (
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [47:0]      s_axis_tdata,
  input  logic [0:0]       s_axis_tuser,
  input  lfk_pkg::cfg_t    cfg,
  input  logic             q_full,
  output logic             q_push,
  output lfk_pkg::q_item_t q_item
);
  import lfk_pkg::*;

  logic [2:0] leg;
  logic signed [14:0] hip_angle;
  logic signed [14:0] knee_angle;
  logic signed [14:0] ankle_angle;
  logic ok;
  logic signed [15:0] yaw;

  assign leg = s_axis_tdata[2:0];
  assign hip_angle = s_axis_tdata[17:3];
  assign knee_angle = s_axis_tdata[32:18];
  assign ankle_angle = s_axis_tdata[47:33];

  assign s_axis_tready = !q_full;
  assign q_push = s_axis_tvalid && !q_full;

  always_comb begin
    ok = (int'(leg) < LEG_COUNT);
    yaw = ok ? YAW_TAB[leg] : 16'sd0;
    q_item.mode = s_axis_tuser[0];
    q_item.leg = leg;
    q_item.ok = ok;
    q_item.ang[0] = split_angle(17'(hip_angle) + 17'(cfg.hip_offset));
    q_item.ang[1] = split_angle(17'(knee_angle) + 17'(cfg.knee_offset));
    q_item.ang[2] = split_angle(17'(ankle_angle) + 17'(cfg.ankle_offset));
    q_item.ang[3] = split_angle(17'(yaw));
  end

endmodule

// File: rtl/lfk_cordic.sv
// Pipelined CORDIC lane giving cosine and sine of a split angle in Q30.
module lfk_cordic (
  input  logic          clk,
  input  logic          en,
  input  lfk_pkg::split_t ang,
  output lfk_pkg::trig_t  cos_o,
  output lfk_pkg::trig_t  sin_o
);
  import lfk_pkg::*;

  cstate_t st [CORDIC_STEPS];
  logic [1:0] qq [CORDIC_STEPS];
  cstate_t st0;

  always_comb begin
    st0.x = CORDIC_GAIN;
    st0.y = '0;
    st0.z = zang_t'(ang.r) <<< 8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= cordic_step(st0, 0);
      qq[0] <= ang.qq;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        st[i] <= cordic_step(st[i-1], i);
        qq[i] <= qq[i-1];
      end
      case (qq[CORDIC_STEPS-1])
        2'd0: begin
          cos_o <= st[CORDIC_STEPS-1].x;
          sin_o <= st[CORDIC_STEPS-1].y;
        end
        2'd1: begin
          cos_o <= -st[CORDIC_STEPS-1].y;
          sin_o <= st[CORDIC_STEPS-1].x;
        end
        2'd2: begin
          cos_o <= -st[CORDIC_STEPS-1].x;
          sin_o <= -st[CORDIC_STEPS-1].y;
        end
        default: begin
          cos_o <= st[CORDIC_STEPS-1].y;
          sin_o <= -st[CORDIC_STEPS-1].x;
        end
      endcase
    end
  end

endmodule

// File: rtl/lfk_back.sv
// Back end: four trig lanes, the rotation chain, mounting transform and output register.
module lfk_back (
  input  logic             clk,
  input  logic             rst,
  input  lfk_pkg::q_item_t item,
  input  logic             item_valid,
  output logic             pop,
  input  lfk_pkg::cfg_t    cfg,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [95:0]      m_axis_tdata
);
  import lfk_pkg::*;

  localparam int SIDE = CORDIC_STEPS + 1;

  logic adv;
  trig_t c [4];
  trig_t s [4];

  logic sv [SIDE];
  logic sm [SIDE];
  logic [2:0] sl [SIDE];
  logic so [SIDE];

  logic [8:1] bv;
  logic mode1;
  logic [2:0] leg1 [7:1];
  logic ok1 [7:1];
  trig_t c3_1, s3_1, c2_1, s2_1, c1_1, s1_1, cy_1, sy_1;
  trig_t c2_2, s2_2, c1_2, s1_2, cy_2, sy_2;
  trig_t c1_3, s1_3, cy_3, sy_3;
  trig_t c1_4, s1_4, cy_4, sy_4;
  trig_t cy_5, sy_5;
  trig_t cy_6, sy_6;
  prod_t p1 [4];
  prod_t p3 [4];
  prod_t q3 [4];
  prod_t p5 [2];
  prod_t q5 [2];
  prod_t p7 [4];
  vec_t vy2, vz2, dy2, dz2;
  vec_t vy4, vz4, dy4, dz4;
  vec_t vz5, dz5;
  vec_t vx6, vy6, vz6;
  vec_t vz7;
  logic [47:0] dir6;
  logic [47:0] dir7;
  vec_t vy0, vz0, ox, oy, oz;

  assign adv = !bv[8] || m_axis_tready;
  assign pop = adv && item_valid;
  assign m_axis_tvalid = bv[8];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    lfk_cordic u_cordic (
      .clk   (clk),
      .en    (adv),
      .ang   (item.ang[g]),
      .cos_o (c[g]),
      .sin_o (s[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE; i++) sv[i] <= 1'b0;
      bv <= '0;
    end else if (adv) begin
      sv[0] <= item_valid;
      for (int i = 1; i < SIDE; i++) sv[i] <= sv[i-1];
      bv <= {bv[7:1], sv[SIDE-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm[0] <= item.mode;
      sl[0] <= item.leg;
      so[0] <= item.ok;
      for (int i = 1; i < SIDE; i++) begin
        sm[i] <= sm[i-1];
        sl[i] <= sl[i-1];
        so[i] <= so[i-1];
      end
      leg1[1] <= sl[SIDE-1];
      ok1[1] <= so[SIDE-1];
      for (int i = 2; i <= 7; i++) begin
        leg1[i] <= leg1[i-1];
        ok1[i] <= ok1[i-1];
      end
    end
  end

  // The mount origin is taken beside the yaw products, one stage before the output register.
  always_comb begin
    mode1 = sm[SIDE-1];
    vy0 = mode1 ? vec_t'($signed(cfg.sensor_mount[31:16])) : vec_t'(cfg.tibia_reach);
    vz0 = mode1 ? vec_t'($signed(cfg.sensor_mount[15:0])) : '0;
    ox = ok1[7] ? vec_t'(ORG_X[leg1[7]]) : '0;
    oy = ok1[7] ? vec_t'(ORG_Y[leg1[7]]) : '0;
    oz = ok1[7] ? vec_t'(ORG_Z[leg1[7]]) : '0;
  end

  // Stage chain: multiply, round and accumulate alternate so that every
  // product is registered before it is summed.
  always_ff @(posedge clk) begin
    if (adv) begin
      // Ankle rotation products.
      p1[0] <= c[2] * vy0;
      p1[1] <= s[2] * vz0;
      p1[2] <= s[2] * vy0;
      p1[3] <= c[2] * vz0;
      c3_1 <= c[2]; s3_1 <= s[2];
      c2_1 <= c[1]; s2_1 <= s[1];
      c1_1 <= c[0]; s1_1 <= s[0];
      cy_1 <= c[3]; sy_1 <= s[3];

      vy2 <= rnd30(p1[0] - p1[1]) + vec_t'(cfg.femur_reach);
      vz2 <= rnd30(p1[2] + p1[3]);
      dy2 <= rnd30(-(prod_t'(s3_1) <<< 14));
      dz2 <= rnd30(prod_t'(c3_1) <<< 14);
      c2_2 <= c2_1; s2_2 <= s2_1; c1_2 <= c1_1; s1_2 <= s1_1;
      cy_2 <= cy_1; sy_2 <= sy_1;

      // Knee rotation products for the position and the direction.
      p3[0] <= c2_2 * vy2;
      p3[1] <= s2_2 * vz2;
      p3[2] <= s2_2 * vy2;
      p3[3] <= c2_2 * vz2;
      q3[0] <= c2_2 * dy2;
      q3[1] <= s2_2 * dz2;
      q3[2] <= s2_2 * dy2;
      q3[3] <= c2_2 * dz2;
      c1_3 <= c1_2; s1_3 <= s1_2; cy_3 <= cy_2; sy_3 <= sy_2;

      vy4 <= rnd30(p3[0] - p3[1]) + vec_t'(cfg.coxa_reach);
      vz4 <= rnd30(p3[2] + p3[3]) + vec_t'(cfg.coxa_rise);
      dy4 <= rnd30(q3[0] - q3[1]);
      dz4 <= rnd30(q3[2] + q3[3]);
      c1_4 <= c1_3; s1_4 <= s1_3; cy_4 <= cy_3; sy_4 <= sy_3;

      // Hip rotation; x is still zero here.
      p5[0] <= s1_4 * vy4;
      p5[1] <= c1_4 * vy4;
      q5[0] <= s1_4 * dy4;
      q5[1] <= c1_4 * dy4;
      vz5 <= vz4;
      dz5 <= dz4;
      cy_5 <= cy_4; sy_5 <= sy_4;

      vx6 <= rnd30(-p5[0]);
      vy6 <= rnd30(p5[1]);
      vz6 <= vz5;
      dir6 <= {sat16(dz5, DIR_MIN, DIR_MAX), sat16(rnd30(q5[1]), DIR_MIN, DIR_MAX),
               sat16(rnd30(-q5[0]), DIR_MIN, DIR_MAX)};
      cy_6 <= cy_5; sy_6 <= sy_5;

      // Mounting yaw.
      p7[0] <= cy_6 * vx6;
      p7[1] <= sy_6 * vy6;
      p7[2] <= sy_6 * vx6;
      p7[3] <= cy_6 * vy6;
      vz7 <= vz6;
      dir7 <= dir6;

      m_axis_tdata <= {dir7,
                       sat16(vz7 + oz, POS_MIN, POS_MAX),
                       sat16(rnd30(p7[2] + p7[3]) + oy, POS_MIN, POS_MAX),
                       sat16(rnd30(p7[0] - p7[1]) + ox, POS_MIN, POS_MAX)};
    end
  end

endmodule

// File: rtl/leg_forward_kinematics_top.sv
// Top level of the leg forward kinematics block with its configuration registers.
//
// Usage: a pose query enters on the s_axis channel: tuser[0] is the mode
// (0 tip position, 1 sensor position) and tdata carries leg, hip, knee and
// ankle angles. One result leaves on m_axis: body-frame position x, y, z
// and the leg-frame sensor direction x, y, z, each 16 bits.
// Configuration registers are written on cfg_valid with cfg_index and
// cfg_data; cfg_ready is always high and indexes above 7 are ignored.
// Write them only while no query is in flight.
// From input acceptance to m_axis_tvalid a query passes the input queue,
// the CORDIC lanes that present cosine and sine, and the rotation chain
// ending in the output register. One item per cycle is sustained while
// the receiver does not stall; the rate is set by the fully pipelined
// CORDIC lanes and multiplier stages.
// When the receiver stalls, the whole back end holds and the four-entry
// queue keeps taking items until it fills, then s_axis_tready falls.
// Reset empties the queue and pipeline and restores the register defaults.
module leg_forward_kinematics_top #(
  parameter int LEG_COUNT = lfk_pkg::LEG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // leg[2:0], hip_angle, knee_angle, ankle_angle
  input  logic [0:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lfk_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  q_item_t wr_item;
  q_item_t rd_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hip_offset <= 16'sd0;
      cfg.knee_offset <= 16'sd0;
      cfg.ankle_offset <= -16'sd5760;
      cfg.coxa_reach <= 16'sd1126;
      cfg.coxa_rise <= 16'sd512;
      cfg.femur_reach <= 16'sd1382;
      cfg.tibia_reach <= 16'sd2534;
      cfg.sensor_mount <= 32'd11731661;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HIP_OFFSET:   cfg.hip_offset <= cfg_data[15:0];
        CFG_KNEE_OFFSET:  cfg.knee_offset <= cfg_data[15:0];
        CFG_ANKLE_OFFSET: cfg.ankle_offset <= cfg_data[15:0];
        CFG_COXA_REACH:   cfg.coxa_reach <= cfg_data[15:0];
        CFG_COXA_RISE:    cfg.coxa_rise <= cfg_data[15:0];
        CFG_FEMUR_REACH:  cfg.femur_reach <= cfg_data[15:0];
        CFG_TIBIA_REACH:  cfg.tibia_reach <= cfg_data[15:0];
        CFG_SENSOR_MOUNT: cfg.sensor_mount <= cfg_data;
        default: ;
      endcase
    end
  end

  lfk_front #(.LEG_COUNT(LEG_COUNT)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg           (cfg),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (wr_item)
  );

  lfk_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  lfk_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (rd_item),
    .item_valid    (!q_empty),
    .pop           (q_pop),
    .cfg           (cfg),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: rtl/lfk_checker.sv
// Port-level checks for the leg forward kinematics block, bound to the top level.
module lfk_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        cfg_ready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[63:48]) >= -16'sd16384 &&
                       $signed(m_axis_tdata[63:48]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[95:80]) >= -16'sd16384 &&
                       $signed(m_axis_tdata[95:80]) <= 16'sd16384))
    else $error("direction outside unit range");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind leg_forward_kinematics_top lfk_checker u_lfk_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);
